// File: hw/rtl/vtq_pkg.sv
// Package for the versioned timer queue: word types, opcodes, result kinds and cell control.
// It depends on nothing; every other file refers to it by scoped names.
package vtq_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_MODIFY = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [1:0] KIND_OK     = 2'd0;
  localparam logic [1:0] KIND_FAIL   = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_TICKED = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  tmr_id;
    logic [15:0] delay;
    logic [15:0] version;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  fired_id;
    logic [15:0] fired_version;
    logic        last;
  } out_word_t;

  // Control broadcast to every cell of the queue.
  typedef struct packed {
    logic        insert;
    logic        pop;
    logic        clear;
    logic [15:0] delay;
    logic [31:0] now;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/vtq_cell.sv
// One slot of the sorted timer queue; it holds one entry and trades it with its neighbors.
// Depends on vtq_pkg for the control struct.
module vtq_cell #(
  parameter int VerBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vtq_pkg::cell_ctrl_t  ctrl_i,
  input  logic [5:0]           new_id_i,
  input  logic [VerBits-1:0]   new_ver_i,
  input  logic [31:0]          new_exp_i,
  input  logic                 left_valid_i,
  input  logic                 left_gt_i,
  input  logic [5:0]           left_id_i,
  input  logic [VerBits-1:0]   left_ver_i,
  input  logic [31:0]          left_exp_i,
  input  logic                 right_valid_i,
  input  logic [5:0]           right_id_i,
  input  logic [VerBits-1:0]   right_ver_i,
  input  logic [31:0]          right_exp_i,
  output logic                 valid_o,
  output logic                 gt_o,
  output logic [5:0]           id_o,
  output logic [VerBits-1:0]   ver_o,
  output logic [31:0]          exp_o
);

  logic               valid_q, valid_d;
  logic [5:0]         id_q, id_d;
  logic [VerBits-1:0] ver_q, ver_d;
  logic [31:0]        exp_q, exp_d;
  logic [31:0]        exp_dist;

  // The entry expires later than the new one when its distance from now is larger.
  assign exp_dist = exp_q - ctrl_i.now;
  assign gt_o = valid_q && (exp_dist > {16'd0, ctrl_i.delay});

  // Clear empties the cell; shift left on pop; on insert take the left entry or the new one.
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    ver_d   = ver_q;
    exp_d   = exp_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      ver_d   = right_ver_i;
      exp_d   = right_exp_i;
    end else if (ctrl_i.insert && left_valid_i) begin
      if (left_gt_i) begin
        valid_d = 1'b1;
        id_d    = left_id_i;
        ver_d   = left_ver_i;
        exp_d   = left_exp_i;
      end else if (!valid_q || gt_o) begin
        valid_d = 1'b1;
        id_d    = new_id_i;
        ver_d   = new_ver_i;
        exp_d   = new_exp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    ver_q <= ver_d;
    exp_q <= exp_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign ver_o   = ver_q;
  assign exp_o   = exp_q;

endmodule

// File: hw/rtl/versioned_timer_queue_top.sv
// A non-tick command gives one word, registered from its execute state; busy is high meanwhile.
// A tick runs S_POP and S_POPD per due entry (version table read, then shift of the cell row).
// Start is taken only while busy is low; the receiver cannot stall and each word shows once.
// Reset clears time, the queue and the known bits at once; the version table is written on use.
// Top level of the versioned timer queue; depends on vtq_pkg and vtq_cell.
module versioned_timer_queue_top #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int ID_COUNT     = 64,
  parameter int VERSION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  vtq_pkg::in_word_t   in_i,
  output logic                busy,
  output logic                result_valid_o,
  output vtq_pkg::out_word_t  result_o
);

  localparam int IdxW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int VB   = VERSION_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_POPD = 2'd3;

  logic [1:0]         state_q, state_d;
  vtq_pkg::in_word_t  cmd_q;
  logic [31:0]        now_q, now_d;
  logic [VB-1:0]      vtab [ID_COUNT];
  logic [VB-1:0]      rd_q;
  logic [ID_COUNT-1:0] known_q, known_d;
  logic [IdxW-1:0]    rd_addr, cmd_idx, head_idx;
  logic               wr_en;
  logic [VB-1:0]      wr_data;
  logic               res_v_d;
  vtq_pkg::out_word_t res_d;
  vtq_pkg::cell_ctrl_t ctrl;
  logic [VB-1:0]      cmd_ver, mod_ver;
  logic               id_bad, full, head_due;
  logic [31:0]        head_dist;

  logic               c_valid [QUEUE_DEPTH+1];
  logic               c_gt    [QUEUE_DEPTH+1];
  logic [5:0]         c_id    [QUEUE_DEPTH+1];
  logic [VB-1:0]      c_ver   [QUEUE_DEPTH+1];
  logic [31:0]        c_exp   [QUEUE_DEPTH+1];

  assign c_valid[QUEUE_DEPTH] = 1'b0;
  assign c_gt[QUEUE_DEPTH]    = 1'b0;
  assign c_id[QUEUE_DEPTH]    = '0;
  assign c_ver[QUEUE_DEPTH]   = '0;
  assign c_exp[QUEUE_DEPTH]   = '0;

  // Row of queue cells, head at index 0.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic          lv, lg;
    logic [5:0]    lid;
    logic [VB-1:0] lver;
    logic [31:0]   lexp;
    if (g == 0) begin : g_head
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lid = '0;
      assign lver = '0;
      assign lexp = '0;
    end else begin : g_body
      assign lv = c_valid[g-1];
      assign lg = c_gt[g-1];
      assign lid = c_id[g-1];
      assign lver = c_ver[g-1];
      assign lexp = c_exp[g-1];
    end
    vtq_cell #(.VerBits(VB)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_id_i     (cmd_q.tmr_id),
      .new_ver_i    (wr_data),
      .new_exp_i    (now_q + {16'd0, cmd_q.delay}),
      .left_valid_i (lv),
      .left_gt_i    (lg),
      .left_id_i    (lid),
      .left_ver_i   (lver),
      .left_exp_i   (lexp),
      .right_valid_i(c_valid[g+1]),
      .right_id_i   (c_id[g+1]),
      .right_ver_i  (c_ver[g+1]),
      .right_exp_i  (c_exp[g+1]),
      .valid_o      (c_valid[g]),
      .gt_o         (c_gt[g]),
      .id_o         (c_id[g]),
      .ver_o        (c_ver[g]),
      .exp_o        (c_exp[g])
    );
  end

  assign busy     = (state_q != S_IDLE);
  assign full     = c_valid[QUEUE_DEPTH-1];
  assign cmd_idx  = IdxW'(cmd_q.tmr_id);
  assign head_idx = IdxW'(c_id[0]);
  assign id_bad   = (32'(cmd_q.tmr_id) >= ID_COUNT);
  assign cmd_ver  = VB'(cmd_q.version);
  assign mod_ver  = (known_q[cmd_idx] ? rd_q : '0) + VB'(1);
  assign head_dist = c_exp[0] - now_q;
  assign head_due = c_valid[0] && ((head_dist == 32'd0) || head_dist[31]);
  assign rd_addr  = (state_q == S_IDLE) ? IdxW'(in_i.tmr_id) : head_idx;

  // Version table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtab[cmd_idx] <= wr_data;
    end
    rd_q <= vtab[rd_addr];
  end

  // Sequencer: command execution and the pop loop of a tick.
  always_comb begin
    state_d = state_q;
    now_d   = now_q;
    known_d = known_q;
    wr_en   = 1'b0;
    wr_data = cmd_ver;
    res_v_d = 1'b0;
    res_d   = '0;
    ctrl    = '0;
    ctrl.delay = cmd_q.delay;
    ctrl.now   = now_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        res_v_d = 1'b1;
        res_d.last = 1'b1;
        res_d.kind = vtq_pkg::KIND_FAIL;
        if (id_bad && (cmd_q.opcode == vtq_pkg::OP_ADD || cmd_q.opcode == vtq_pkg::OP_MODIFY
            || cmd_q.opcode == vtq_pkg::OP_DELETE)) begin
          res_d.fired_id = cmd_q.tmr_id;
        end else begin
          case (cmd_q.opcode)
            vtq_pkg::OP_ADD: begin
              res_d.fired_id = cmd_q.tmr_id;
              res_d.fired_version = 16'(cmd_ver);
              if (!full) begin
                ctrl.insert = 1'b1;
                wr_en = 1'b1;
                known_d[cmd_idx] = 1'b1;
                res_d.kind = vtq_pkg::KIND_OK;
              end
            end
            vtq_pkg::OP_MODIFY: begin
              wr_data = mod_ver;
              wr_en = 1'b1;
              known_d[cmd_idx] = 1'b1;
              res_d.fired_id = cmd_q.tmr_id;
              res_d.fired_version = 16'(mod_ver);
              if (!full) begin
                ctrl.insert = 1'b1;
                res_d.kind = vtq_pkg::KIND_OK;
              end
            end
            vtq_pkg::OP_DELETE: begin
              res_d.fired_id = cmd_q.tmr_id;
              wr_data = '0;
              if (known_q[cmd_idx]) begin
                wr_en = 1'b1;
                res_d.kind = vtq_pkg::KIND_OK;
              end
            end
            vtq_pkg::OP_CLEAR: begin
              ctrl.clear = 1'b1;
              res_d.kind = vtq_pkg::KIND_OK;
            end
            vtq_pkg::OP_TICK: begin
              res_v_d = 1'b0;
              now_d = now_q + 32'd1;
              state_d = S_POP;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (head_due) begin
          state_d = S_POPD;
        end else begin
          state_d = S_IDLE;
          res_v_d = 1'b1;
          res_d.kind = vtq_pkg::KIND_TICKED;
          res_d.last = 1'b1;
        end
      end
      S_POPD: begin
        // The table word for the head id is in rd_q now.
        state_d = S_POP;
        ctrl.pop = 1'b1;
        if (!(known_q[head_idx] && rd_q != c_ver[0])) begin
          if (c_ver[0] == '0) begin
            known_d[head_idx] = 1'b0;
          end else begin
            res_v_d = 1'b1;
            res_d.kind = vtq_pkg::KIND_FIRED;
            res_d.fired_id = c_id[0];
            res_d.fired_version = 16'(c_ver[0]);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      now_q          <= '0;
      known_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      now_q          <= now_d;
      known_q        <= known_d;
      result_valid_o <= res_v_d;
    end
  end

  // Command and result words.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= in_i;
    end
    result_o <= res_d;
  end

  // A word with the last flag ends the item, so the block is free again.
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy)
    else $error("block still busy after the last word");

  // An accepted command is held off from the next one.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // The queue cells fill from the head; a valid tail cell implies a valid head cell.
  a_head_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[QUEUE_DEPTH-1] |-> c_valid[0])
    else $error("queue tail valid with empty head");

endmodule

// File: sim/versioned_timer_queue_top_tb.sv
// Self-checking testbench for the versioned timer queue: drives add, modify, delete, clear,
// tick and undefined words and checks every result word against an in-bench predictor of the queue.
// Depends on vtq_pkg and the versioned_timer_queue_top RTL.
module versioned_timer_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 32;
  localparam int NIDS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // Predictor of the queue and the version table, with the store of expected words.
  class timer_scoreboard;
    logic [31:0] now_sec;
    logic [5:0]  q_id[$];
    logic [15:0] q_ver[$];
    logic [31:0] q_exp[$];
    logic [15:0] ver_tab[NIDS];
    bit          known[NIDS];
    vtq_pkg::out_word_t expected_words[$];
    int          mismatches;

    function new();
      now_sec = 0;
      mismatches = 0;
      foreach (known[i]) begin
        known[i] = 0;
        ver_tab[i] = 0;
      end
    endfunction

    function void push_word(logic [1:0] k, logic [5:0] id, logic [15:0] v, logic l);
      vtq_pkg::out_word_t w;
      w.kind = k;
      w.fired_id = id;
      w.fired_version = v;
      w.last = l;
      expected_words = {expected_words, w};
    endfunction

    // Stable insert by distance from now; returns 0 when the queue is full.
    function bit enqueue(logic [5:0] id, logic [15:0] v, logic [15:0] dly);
      int pos;
      logic [31:0] gap;
      if (q_id.size() >= QDEPTH) return 0;
      pos = q_id.size();
      while (pos > 0) begin
        gap = q_exp[pos-1] - now_sec;
        if (gap > {16'd0, dly}) pos--;
        else break;
      end
      q_id.insert(pos, id);
      q_ver.insert(pos, v);
      q_exp.insert(pos, now_sec + {16'd0, dly});
      return 1;
    endfunction

    function void note_word(vtq_pkg::in_word_t w);
      logic [15:0] nv;
      logic [31:0] gap;
      bit          ok;
      case (w.opcode)
        vtq_pkg::OP_ADD: begin
          if (enqueue(w.tmr_id, w.version, w.delay)) begin
            ver_tab[w.tmr_id] = w.version;
            known[w.tmr_id] = 1;
            push_word(vtq_pkg::KIND_OK, w.tmr_id, w.version, 1);
          end else begin
            push_word(vtq_pkg::KIND_FAIL, w.tmr_id, w.version, 1);
          end
        end
        vtq_pkg::OP_MODIFY: begin
          nv = (known[w.tmr_id] ? ver_tab[w.tmr_id] : 16'd0) + 16'd1;
          ver_tab[w.tmr_id] = nv;
          known[w.tmr_id] = 1;
          ok = enqueue(w.tmr_id, nv, w.delay);
          push_word(ok ? vtq_pkg::KIND_OK : vtq_pkg::KIND_FAIL, w.tmr_id, nv, 1);
        end
        vtq_pkg::OP_DELETE: begin
          if (known[w.tmr_id]) begin
            ver_tab[w.tmr_id] = 0;
            push_word(vtq_pkg::KIND_OK, w.tmr_id, 16'd0, 1);
          end else begin
            push_word(vtq_pkg::KIND_FAIL, w.tmr_id, 16'd0, 1);
          end
        end
        vtq_pkg::OP_CLEAR: begin
          q_id.delete();
          q_ver.delete();
          q_exp.delete();
          push_word(vtq_pkg::KIND_OK, 6'd0, 16'd0, 1);
        end
        vtq_pkg::OP_TICK: begin
          now_sec++;
          // Pop every due entry; stale ones vanish, version zero forgets the id.
          while (q_id.size() > 0) begin
            gap = q_exp[0] - now_sec;
            if (gap != 0 && gap < 32'h8000_0000) break;
            if (!(known[q_id[0]] && ver_tab[q_id[0]] != q_ver[0])) begin
              if (q_ver[0] == 0) known[q_id[0]] = 0;
              else push_word(vtq_pkg::KIND_FIRED, q_id[0], q_ver[0], 0);
            end
            void'(q_id.pop_front());
            void'(q_ver.pop_front());
            void'(q_exp.pop_front());
          end
          push_word(vtq_pkg::KIND_TICKED, 6'd0, 16'd0, 1);
        end
        default: push_word(vtq_pkg::KIND_FAIL, 6'd0, 16'd0, 1);
      endcase
    endfunction

    function void check_word(vtq_pkg::out_word_t got);
      vtq_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.kind !== exp_w.kind || got.fired_id !== exp_w.fired_id ||
          got.fired_version !== exp_w.fired_version || got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_w, got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  vtq_pkg::in_word_t  in_i;
  logic               busy;
  logic               result_valid_o;
  vtq_pkg::out_word_t result_o;

  timer_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  versioned_timer_queue_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .in_i(in_i),
    .busy(busy), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Result checking and the watchdog on handshakes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_word(result_o);
      if (result_valid_o || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Send one word, with a random gap first; returns in the cycle after it is accepted.
  task automatic send_word(vtq_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
    start <= 1'b0;
    // The block is busy in the cycle after an accept, so no chance to send is lost here.
    @(posedge clk_i);
  endtask

  task automatic send_op(logic [2:0] op, logic [5:0] id, logic [15:0] dly, logic [15:0] v);
    vtq_pkg::in_word_t w;
    w.opcode = op;
    w.tmr_id = id;
    w.delay = dly;
    w.version = v;
    send_word(w);
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Adds, modifies, deletes and ticks, mostly on ids 0-7 and short delays; rare clears and undefined opcodes.
  task automatic random_word();
    int r;
    logic [5:0] id;
    logic [15:0] dly;
    r = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
    dly = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    if (r < 25) send_op(vtq_pkg::OP_ADD, id, dly, 16'($urandom));
    else if (r < 45) send_op(vtq_pkg::OP_MODIFY, id, dly, 16'($urandom));
    else if (r < 55) send_op(vtq_pkg::OP_DELETE, id, dly, 16'($urandom));
    else if (r < 58) send_op(vtq_pkg::OP_CLEAR, id, dly, 16'($urandom));
    else if (r < 96) send_op(vtq_pkg::OP_TICK, id, dly, 16'($urandom));
    else send_op(3'($urandom_range(7, 5)), id, dly, 16'($urandom));
  endtask

  initial begin
    sb = new();
    idle_pct = 26;
    quiet_cycles = 0;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: extremes, each operation and the special cases.
    send_op(vtq_pkg::OP_DELETE, 6'd63, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_ADD, 6'd0, 16'd0, 16'hFFFF);
    send_op(vtq_pkg::OP_MODIFY, 6'd0, 16'd1, 16'h0000);
    send_op(vtq_pkg::OP_MODIFY, 6'd5, 16'd0, 16'h1234);
    send_op(vtq_pkg::OP_ADD, 6'd63, 16'hFFFF, 16'h0000);
    send_op(vtq_pkg::OP_ADD, 6'd7, 16'd1, 16'hFFFF);
    send_op(vtq_pkg::OP_MODIFY, 6'd7, 16'd1, 16'd0);
    send_op(vtq_pkg::OP_DELETE, 6'd5, 16'd0, 16'hFFFF);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
    send_op(3'd5, 6'd1, 16'd1, 16'd1);
    send_op(3'd7, 6'd63, 16'hFFFF, 16'hFFFF);
    send_op(vtq_pkg::OP_CLEAR, 6'd3, 16'd3, 16'd3);
    // Fill the queue, then overflow with add and modify.
    for (int i = 0; i < QDEPTH; i++) send_op(vtq_pkg::OP_ADD, 6'(i), 16'(i % 3), 16'(i + 1));
    send_op(vtq_pkg::OP_ADD, 6'd40, 16'd0, 16'd9);
    send_op(vtq_pkg::OP_MODIFY, 6'd1, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
    // Version wrap: modify from 0xFFFF lands on zero and forgets the id when it pops.
    send_op(vtq_pkg::OP_ADD, 6'd9, 16'd0, 16'hFFFF);
    send_op(vtq_pkg::OP_MODIFY, 6'd9, 16'd0, 16'd0);
    send_op(vtq_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);

    // Pause with the sender until everything has come back.
    wait_drained();

    for (int i = 0; i < 280; i++) begin
      if (i == 93) idle_pct = 63;
      if (i == 187) idle_pct = 0;
      random_word();
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/vtq_pkg.sv
hw/rtl/vtq_cell.sv
hw/rtl/versioned_timer_queue_top.sv
sim/versioned_timer_queue_top_tb.sv
